// ----- rtl/core/bpe_gme_pkg.sv -----
package bpe_gme_pkg;

  localparam logic CMD_WRITE_MERGE = 1'b0;
  localparam logic CMD_TEXT_BYTE   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS_START,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_TSCAN,
    ST_POS_DONE,
    ST_MERGE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

// ----- rtl/core/bpe_greedy_merge_encoder_core.sv -----
// Merge-table writes and text bytes: one transfer per cycle while idle.
// Encoding: each pass scans every adjacent buffer pair against the table,
// top entry down, one table read per cycle, then merges the chosen pair and
// shifts the buffer tail down; a pass with no match sends the tokens out.
// rst clears control state, length, overflow flag and merges_in_use; both
// memories are undefined until written and need no clearing pass.
module bpe_greedy_merge_encoder_core #(
  parameter int MAX_TOKENS = 64,
  parameter int MAX_MERGES = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,   // merges_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[9:0], pair_left[25:10], pair_right[41:26], merged_id[57:42],
  // text_byte[65:58], zero[71:66]
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,     // end_of_text
  input  logic [0:0]  s_tuser,     // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // token_id
  output logic        m_tlast,     // last_token
  output logic [0:0]  m_tuser      // truncated
);

  localparam int JW = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;
  localparam int PW = $clog2(MAX_TOKENS);
  localparam int LW = $clog2(MAX_TOKENS + 1);
  localparam int CW = LW + 1;

  bpe_gme_pkg::state_t state, state_next;

  logic [3*ID_BITS-1:0] tbl_mem [MAX_MERGES];
  logic [ID_BITS-1:0]   buf_mem [MAX_TOKENS];

  logic [3*ID_BITS-1:0] tbl_rdata;
  logic [JW-1:0]        tbl_raddr;
  logic                 tbl_we;
  logic [JW-1:0]        tbl_waddr;
  logic [3*ID_BITS-1:0] tbl_wdata;

  logic [ID_BITS-1:0]   buf_rdata;
  logic [PW-1:0]        buf_raddr;
  logic                 buf_we;
  logic [PW-1:0]        buf_waddr;
  logic [ID_BITS-1:0]   buf_wdata;

  logic [10:0]          merges_in_use;
  logic [LW-1:0]        len;
  logic                 ovf;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        sh;
  logic [PW-1:0]        k;
  logic [JW-1:0]        j;
  logic [ID_BITS-1:0]   tok_a;
  logic [ID_BITS-1:0]   tok_b;
  logic                 found;
  logic [JW-1:0]        best_idx;
  logic [PW-1:0]        merge_pos;
  logic [ID_BITS-1:0]   best_merged;

  logic [31:0]          miu_ext;
  logic [31:0]          eidx_ext;
  logic [JW:0]          n_eff;
  logic                 accept;
  logic                 is_merge_wr;
  logic                 buf_has_room;
  logic                 tbl_hit;
  logic                 more_pos;
  logic                 more_shift;
  logic                 emit_last;
  logic                 pass_go;

  logic [ID_BITS+15:0]  left_ext;
  logic [ID_BITS+15:0]  right_ext;
  logic [ID_BITS+15:0]  merged_ext;
  logic [ID_BITS+7:0]   byte_ext;
  logic [ID_BITS+15:0]  out_ext;
  logic [ID_BITS-1:0]   ent_left;
  logic [ID_BITS-1:0]   ent_right;
  logic [ID_BITS-1:0]   ent_merged;

  assign miu_ext   = {21'd0, merges_in_use};
  assign eidx_ext  = {22'd0, s_tdata[9:0]};
  assign n_eff     = (miu_ext > 32'(MAX_MERGES)) ? (JW+1)'(MAX_MERGES) : miu_ext[JW:0];

  assign left_ext   = {{ID_BITS{1'b0}}, s_tdata[25:10]};
  assign right_ext  = {{ID_BITS{1'b0}}, s_tdata[41:26]};
  assign merged_ext = {{ID_BITS{1'b0}}, s_tdata[57:42]};
  assign byte_ext   = {{ID_BITS{1'b0}}, s_tdata[65:58]};

  assign ent_left   = tbl_rdata[ID_BITS-1:0];
  assign ent_right  = tbl_rdata[2*ID_BITS-1:ID_BITS];
  assign ent_merged = tbl_rdata[3*ID_BITS-1:2*ID_BITS];

  assign accept       = s_tvalid && s_tready;
  assign is_merge_wr  = (s_tuser[0] == bpe_gme_pkg::CMD_WRITE_MERGE);
  assign buf_has_room = (CW'(len) < CW'(MAX_TOKENS));
  assign tbl_hit      = (ent_left == tok_a) && (ent_right == tok_b);
  assign more_pos     = (CW'(pos) + CW'(2)) < CW'(len);
  assign more_shift   = (CW'(sh) + CW'(1)) < CW'(len);
  assign emit_last    = (CW'(k) + CW'(1)) == CW'(len);
  assign pass_go      = (CW'(len) >= CW'(2)) && (n_eff != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpe_gme_pkg::ST_IDLE: begin
        if (accept && !is_merge_wr && s_tlast) state_next = bpe_gme_pkg::ST_PASS_START;
      end
      bpe_gme_pkg::ST_PASS_START: begin
        state_next = pass_go ? bpe_gme_pkg::ST_LOAD_A : bpe_gme_pkg::ST_EMIT_RD;
      end
      bpe_gme_pkg::ST_LOAD_A:   state_next = bpe_gme_pkg::ST_LOAD_B;
      bpe_gme_pkg::ST_LOAD_B:   state_next = bpe_gme_pkg::ST_TSCAN;
      bpe_gme_pkg::ST_TSCAN: begin
        if (tbl_hit || j == '0) state_next = bpe_gme_pkg::ST_POS_DONE;
      end
      bpe_gme_pkg::ST_POS_DONE: begin
        priority if (more_pos) state_next = bpe_gme_pkg::ST_LOAD_B;
        else if (found)        state_next = bpe_gme_pkg::ST_MERGE;
        else                   state_next = bpe_gme_pkg::ST_EMIT_RD;
      end
      bpe_gme_pkg::ST_MERGE:    state_next = bpe_gme_pkg::ST_SHIFT_RD;
      bpe_gme_pkg::ST_SHIFT_RD: begin
        state_next = more_shift ? bpe_gme_pkg::ST_SHIFT_WR : bpe_gme_pkg::ST_PASS_START;
      end
      bpe_gme_pkg::ST_SHIFT_WR: state_next = bpe_gme_pkg::ST_SHIFT_RD;
      bpe_gme_pkg::ST_EMIT_RD:  state_next = bpe_gme_pkg::ST_EMIT_LD;
      bpe_gme_pkg::ST_EMIT_LD:  state_next = bpe_gme_pkg::ST_EMIT_WAIT;
      bpe_gme_pkg::ST_EMIT_WAIT: begin
        if (m_tready) state_next = m_tlast ? bpe_gme_pkg::ST_IDLE : bpe_gme_pkg::ST_EMIT_RD;
      end
      default: state_next = bpe_gme_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    buf_raddr = '0;
    tbl_raddr = j;
    buf_we    = 1'b0;
    buf_waddr = sh;
    buf_wdata = buf_rdata;
    tbl_we    = 1'b0;
    tbl_waddr = eidx_ext[JW-1:0];
    tbl_wdata = {merged_ext[ID_BITS-1:0], right_ext[ID_BITS-1:0], left_ext[ID_BITS-1:0]};
    unique case (state)
      bpe_gme_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        tbl_we    = accept && is_merge_wr && (eidx_ext < 32'(MAX_MERGES));
        buf_we    = accept && !is_merge_wr && buf_has_room;
        buf_waddr = len[PW-1:0];
        buf_wdata = byte_ext[ID_BITS-1:0];
      end
      bpe_gme_pkg::ST_LOAD_A:   buf_raddr = pos + PW'(1);
      bpe_gme_pkg::ST_LOAD_B:   tbl_raddr = JW'(n_eff - (JW+1)'(1));
      bpe_gme_pkg::ST_TSCAN:    tbl_raddr = j - JW'(1);
      bpe_gme_pkg::ST_POS_DONE: buf_raddr = pos + PW'(2);
      bpe_gme_pkg::ST_MERGE: begin
        buf_we    = 1'b1;
        buf_waddr = merge_pos;
        buf_wdata = best_merged;
      end
      bpe_gme_pkg::ST_SHIFT_RD: buf_raddr = sh + PW'(1);
      bpe_gme_pkg::ST_SHIFT_WR: buf_we = 1'b1;
      bpe_gme_pkg::ST_EMIT_RD:  buf_raddr = k;
      bpe_gme_pkg::ST_EMIT_WAIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rdata <= buf_mem[buf_raddr];
  end

  assign out_ext = {16'd0, buf_rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bpe_gme_pkg::ST_IDLE;
      merges_in_use <= '0;
      len           <= '0;
      ovf           <= 1'b0;
      found         <= 1'b0;
      m_tlast       <= 1'b0;
      m_tuser       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) merges_in_use <= cfg_wdata;
      unique case (state)
        bpe_gme_pkg::ST_IDLE: begin
          if (accept && !is_merge_wr) begin
            if (buf_has_room) len <= len + LW'(1);
            else              ovf <= 1'b1;
          end
        end
        bpe_gme_pkg::ST_PASS_START: begin
          found <= 1'b0;
          pos   <= '0;
        end
        bpe_gme_pkg::ST_LOAD_A: tok_b <= buf_rdata;
        bpe_gme_pkg::ST_LOAD_B: begin
          tok_a <= tok_b;
          tok_b <= buf_rdata;
          j     <= JW'(n_eff - (JW+1)'(1));
        end
        bpe_gme_pkg::ST_TSCAN: begin
          if (tbl_hit) begin
            if (!found || j < best_idx) begin
              found       <= 1'b1;
              best_idx    <= j;
              merge_pos   <= pos;
              best_merged <= ent_merged;
            end
          end else if (j != '0) begin
            j <= j - JW'(1);
          end
        end
        bpe_gme_pkg::ST_POS_DONE: begin
          if (more_pos) pos <= pos + PW'(1);
          k <= '0;
        end
        bpe_gme_pkg::ST_MERGE: sh <= merge_pos + PW'(1);
        bpe_gme_pkg::ST_SHIFT_RD: begin
          if (!more_shift) len <= len - LW'(1);
        end
        bpe_gme_pkg::ST_SHIFT_WR: sh <= sh + PW'(1);
        bpe_gme_pkg::ST_EMIT_LD: begin
          m_tdata    <= out_ext[15:0];
          m_tlast    <= emit_last;
          m_tuser[0] <= emit_last && ovf;
        end
        bpe_gme_pkg::ST_EMIT_WAIT: begin
          if (m_tready) begin
            if (m_tlast) begin
              len <= '0;
              ovf <= 1'b0;
            end else begin
              k <= k + PW'(1);
            end
          end
        end
        default: ;
      endcase
      if (state == bpe_gme_pkg::ST_PASS_START) k <= '0;
    end
  end

endmodule
